// ===== hdl/wpm_pkg.sv =====
// shared types, constants and byte helpers for the wildcard pattern matcher
package wpm_pkg;

   localparam int DEFAULT_PATTERN_DEPTH = 64;
   localparam int QUEUE_DEPTH           = 2;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_ESC   = 8'h5C;

   localparam logic [1:0] ACT_APPEND  = 2'd0;
   localparam logic [1:0] ACT_SUBJECT = 2'd1;
   localparam logic [1:0] ACT_END     = 2'd2;
   localparam logic [1:0] ACT_CLEAR   = 2'd3;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_SUBJECT,
      OP_END,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB_C,
      ST_SUB_STAR,
      ST_SUB_TGT,
      ST_SUB_LIT,
      ST_WALK_C,
      ST_WALK_STAR
   } state_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
      logic [7:0] r;
      r = b;
      if (fold && b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   function automatic logic same_byte(input logic [7:0] a, input logic [7:0] b,
                                      input logic fold);
      return fold_byte(a, fold) == fold_byte(b, fold);
   endfunction

endpackage

// ===== hdl/wpm_front.sv =====
// front end: accepts beats, decodes the action and queues the items
module wpm_front
   import wpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [1:0] action
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
   localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);

   item_type       entry_ff [QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   item_type       push_item;
   logic           push;

   always_comb begin
      push_item.data = req_tdata;
      unique case (req_tuser)
         ACT_APPEND:  push_item.op = OP_APPEND;
         ACT_SUBJECT: push_item.op = OP_SUBJECT;
         ACT_END:     push_item.op = OP_END;
         ACT_CLEAR:   push_item.op = OP_CLEAR;
         default:     push_item.op = OP_CLEAR;
      endcase
   end

   assign req_tready = (count_ff != QFULL);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QLAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QLAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/wpm_engine.sv =====
// back end: pattern store, matching sequencer and result register
module wpm_engine
   import wpm_pkg::*;
#(
   parameter int PATTERN_DEPTH = DEFAULT_PATTERN_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  logic       q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

   localparam int AW = $clog2(PATTERN_DEPTH);
   localparam int CW = $clog2(PATTERN_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(PATTERN_DEPTH);

   state_type      state_ff, state_in;
   logic [CW-1:0]  len_ff, len_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic           star_ff, star_in;
   logic [7:0]     tgt_ff, tgt_in;
   logic           rest_ff, rest_in;
   logic           fail_ff, fail_in;
   logic           ovf_ff, ovf_in;
   logic           fold_ff;
   logic [7:0]     byte_ff, byte_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           match_ff, match_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic [7:0]     mem [PATTERN_DEPTH];
   logic [7:0]     rd_data_ff;
   logic           rd_en;
   logic [CW-1:0]  rd_ptr;
   logic           wr_en;

   logic           can_pop;
   logic           rd_star, rd_esc, rd_quest;
   logic [CW-1:0]  ptr_p1;
   logic           ptr_p1_lt;
   logic           sub_hit;
   logic           idle_hit;
   logic           pos_lt;
   logic [CW-1:0]  walk_start;
   logic           walk_start_lt;
   logic [CW:0]    walk_nxt;
   logic           walk_nxt_lt;

   assign can_pop   = q_valid && (q_item.op != OP_END || !rsp_valid_ff);
   assign rd_star   = (rd_data_ff == CH_STAR);
   assign rd_esc    = (rd_data_ff == CH_ESC);
   assign rd_quest  = (rd_data_ff == CH_QUEST);
   assign ptr_p1    = ptr_ff + 1'b1;
   assign ptr_p1_lt = (ptr_p1 < len_ff);
   assign sub_hit   = same_byte(rd_data_ff, byte_ff, fold_ff);
   assign idle_hit  = same_byte(tgt_ff, q_item.data, fold_ff);
   assign pos_lt    = (pos_ff < len_ff);
   // a pending star at end of subject eats its target
   assign walk_start    = pos_ff + CW'(star_ff);
   assign walk_start_lt = (walk_start < len_ff);
   assign walk_nxt      = {1'b0, ptr_ff} + (rd_esc ? (CW+1)'(2) : (CW+1)'(1));
   assign walk_nxt_lt   = (walk_nxt < {1'b0, len_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (can_pop) begin
               if (q_item.op == OP_SUBJECT && !fail_ff && !rest_ff && !star_ff && pos_lt) begin
                  state_in = ST_SUB_C;
               end else if (q_item.op == OP_END && !fail_ff && !rest_ff && walk_start_lt) begin
                  state_in = ST_WALK_C;
               end
            end
         end
         ST_SUB_C: begin
            if (rd_star && ptr_p1_lt) begin
               state_in = ST_SUB_STAR;
            end else if (rd_esc && ptr_p1_lt) begin
               state_in = ST_SUB_LIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUB_STAR: begin
            state_in = (rd_esc && ptr_p1_lt) ? ST_SUB_TGT : ST_IDLE;
         end
         ST_SUB_TGT: state_in = ST_IDLE;
         ST_SUB_LIT: state_in = ST_IDLE;
         ST_WALK_C: begin
            state_in = (rd_star && ptr_p1_lt) ? ST_WALK_STAR : ST_IDLE;
         end
         ST_WALK_STAR: begin
            state_in = walk_nxt_lt ? ST_WALK_C : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and strobes
   always_comb begin
      len_in       = len_ff;
      pos_in       = pos_ff;
      ptr_in       = ptr_ff;
      star_in      = star_ff;
      tgt_in       = tgt_ff;
      rest_in      = rest_ff;
      fail_in      = fail_ff;
      ovf_in       = ovf_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      match_in     = match_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_ptr       = ptr_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (can_pop) begin
               q_pop = 1'b1;
               unique case (q_item.op)
                  OP_APPEND: begin
                     if (len_ff < DEPTH_C) begin
                        wr_en  = 1'b1;
                        len_in = len_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     len_in  = '0;
                     ovf_in  = 1'b0;
                     pos_in  = '0;
                     star_in = 1'b0;
                     tgt_in  = '0;
                     rest_in = 1'b0;
                     fail_in = 1'b0;
                  end
                  OP_SUBJECT: begin
                     byte_in = q_item.data;
                     if (!fail_ff && !rest_ff) begin
                        if (star_ff) begin
                           if (idle_hit) begin
                              star_in = 1'b0;
                              pos_in  = pos_ff + 1'b1;
                           end
                        end else if (!pos_lt) begin
                           fail_in = 1'b1;
                        end else begin
                           rd_en  = 1'b1;
                           rd_ptr = pos_ff;
                           ptr_in = pos_ff;
                        end
                     end
                  end
                  OP_END: begin
                     if (fail_ff || rest_ff || !walk_start_lt) begin
                        rsp_valid_in = 1'b1;
                        match_in     = !fail_ff;
                        rsp_ovf_in   = ovf_ff;
                        pos_in       = '0;
                        star_in      = 1'b0;
                        tgt_in       = '0;
                        rest_in      = 1'b0;
                        fail_in      = 1'b0;
                     end else begin
                        rd_en  = 1'b1;
                        rd_ptr = walk_start;
                        ptr_in = walk_start;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SUB_C: begin
            if (rd_star) begin
               if (ptr_p1_lt) begin
                  rd_en  = 1'b1;
                  rd_ptr = ptr_p1;
                  ptr_in = ptr_p1;
               end else begin
                  rest_in = 1'b1;
                  pos_in  = ptr_p1;
               end
            end else if (rd_quest) begin
               pos_in = ptr_p1;
            end else if (rd_esc) begin
               if (ptr_p1_lt) begin
                  rd_en  = 1'b1;
                  rd_ptr = ptr_p1;
                  ptr_in = ptr_p1;
               end else begin
                  fail_in = 1'b1;
               end
            end else if (sub_hit) begin
               pos_in = ptr_p1;
            end else begin
               fail_in = 1'b1;
            end
         end
         ST_SUB_STAR, ST_SUB_TGT: begin
            if (state_ff == ST_SUB_STAR && rd_esc) begin
               if (ptr_p1_lt) begin
                  rd_en  = 1'b1;
                  rd_ptr = ptr_p1;
                  ptr_in = ptr_p1;
               end else begin
                  rest_in = 1'b1;
                  pos_in  = ptr_p1;
               end
            end else begin
               // star target is always literal
               tgt_in = rd_data_ff;
               if (sub_hit) begin
                  pos_in = ptr_p1;
               end else begin
                  star_in = 1'b1;
                  pos_in  = ptr_ff;
               end
            end
         end
         ST_SUB_LIT: begin
            if (sub_hit) begin
               pos_in = ptr_p1;
            end else begin
               fail_in = 1'b1;
            end
         end
         ST_WALK_C, ST_WALK_STAR: begin
            if (state_ff == ST_WALK_C && rd_star && ptr_p1_lt) begin
               rd_en  = 1'b1;
               rd_ptr = ptr_p1;
               ptr_in = ptr_p1;
            end else if (state_ff == ST_WALK_STAR && walk_nxt_lt) begin
               rd_en  = 1'b1;
               rd_ptr = walk_nxt[CW-1:0];
               ptr_in = walk_nxt[CW-1:0];
            end else begin
               rsp_valid_in = 1'b1;
               if (state_ff == ST_WALK_STAR || rd_star) begin
                  match_in = 1'b1;
               end else begin
                  // lone trailing backslash still matches
                  match_in = rd_esc && !ptr_p1_lt;
               end
               rsp_ovf_in = ovf_ff;
               pos_in     = '0;
               star_in    = 1'b0;
               tgt_in     = '0;
               rest_in    = 1'b0;
               fail_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         pos_ff       <= '0;
         star_ff      <= 1'b0;
         tgt_ff       <= '0;
         rest_ff      <= 1'b0;
         fail_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         fold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         star_ff      <= star_in;
         tgt_ff       <= tgt_in;
         rest_ff      <= rest_in;
         fail_ff      <= fail_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            fold_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      byte_ff    <= byte_in;
      match_ff   <= match_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // pattern store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[len_ff[AW-1:0]] <= q_item.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, match_ff};

`ifndef NO_ASSERTIONS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= DEPTH_C)
      else $error("pattern length beyond store depth");

   a_no_end_over_result: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_item.op != OP_END || !rsp_valid_ff))
      else $error("end of subject taken while result pending");

   a_star_exclusive: assert property (@(posedge clock) disable iff (reset)
      star_ff |-> (!rest_ff && !fail_ff))
      else $error("star pending together with accept or fail");

   a_restart_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (pos_ff == '0 && !star_ff && !fail_ff && !rest_ff))
      else $error("matching state not restarted after result");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (ptr_ff < len_ff))
      else $error("store read outside written pattern");
`endif

endmodule

// ===== hdl/wildcard_pattern_matcher_unit.sv =====
// top level of the wildcard pattern matcher
//
//  channel   ports                          contents
//  request   req_tvalid/tready/tdata/tuser  tdata[7:0] data_byte, tuser[1:0] action
//  response  rsp_tvalid/tready/tdata        tdata[0] matched, tdata[1] pattern_overflow
//  control   csr_we/csr_wdata               case_fold
//
// append and clear are taken in the idle state; a subject byte is matched through
// registered reads of the pattern store (escape and star lookups each add one read)
// end of subject answers from idle, or walks trailing stars through ST_WALK_C and ST_WALK_STAR
// a two-beat queue decouples the request side from the sequencer
// a pending response only blocks the next end-of-subject beat
// synchronous reset clears control state; the pattern store needs no clearing pass
module wildcard_pattern_matcher_unit
   import wpm_pkg::*;
#(
   parameter int PATTERN_DEPTH = DEFAULT_PATTERN_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,     // case_fold
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] data_byte
   input  logic [1:0] req_tuser,     // [1:0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata      // [0] matched, [1] pattern_overflow, [7:2] zero
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   wpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   wpm_engine #(
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
